/* rtl/ethip_pkg.sv */
// ----------------------------------------------------------------------------
// ethip_pkg
// Shared types, codes and helpers of the Ethernet/IPv4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ethip_pkg;

  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TCP_SHORT = 2'd1;
  localparam logic [1:0] STAT_TRUNC     = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } ethip_byte_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [15:0] extra_info;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } ethip_rec_t;

  // transport header length in bytes, zero for other protocols
  function automatic logic [4:0] l4_len(input logic [7:0] proto);
    logic [4:0] len;
    len = 5'd0;
    if (proto == PROTO_TCP) begin
      len = 5'd20;
    end else if (proto == PROTO_UDP) begin
      len = 5'd8;
    end else if (proto == PROTO_ICMP) begin
      len = 5'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/ethip_byte_if.sv */
// ----------------------------------------------------------------------------
// ethip_byte_if
// Frame byte channel: one captured byte per item with an end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ethip_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/ethip_cfg_if.sv */
// ----------------------------------------------------------------------------
// ethip_cfg_if
// Configuration write channel carrying the link type register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ethip_cfg_if;
  logic valid;
  logic ready;
  logic link_type;

  modport source (output valid, output link_type, input ready);
  modport sink   (input valid, input link_type, output ready);
endinterface

`default_nettype wire

/* rtl/ethip_rec_if.sv */
// ----------------------------------------------------------------------------
// ethip_rec_if
// Result channel: header records and payload byte records.
// ----------------------------------------------------------------------------
`default_nettype none

interface ethip_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] sequence_number;
  logic [31:0] ack_number;
  logic [15:0] extra_info;
  logic [1:0]  status;
  logic [7:0]  payload_byte;
  logic        last_of_frame;

  modport source (
    output valid, output record_kind, output ip_protocol, output source_address,
    output dest_address, output source_port, output dest_port,
    output sequence_number, output ack_number, output extra_info, output status,
    output payload_byte, output last_of_frame, input ready
  );
  modport sink (
    input valid, input record_kind, input ip_protocol, input source_address,
    input dest_address, input source_port, input dest_port,
    input sequence_number, input ack_number, input extra_info, input status,
    input payload_byte, input last_of_frame, output ready
  );
endinterface

`default_nettype wire

/* rtl/ethernet_ipv4_header_parser.sv */
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser
// Parses Ethernet/VLAN/IPv4/TCP/UDP/ICMP headers from a byte stream and emits
// one header record per IPv4 packet followed by payload byte records.
//
//   channel  dir  handshake     payload
//   byte_i   in   valid/ready   frame_byte, frame_end
//   cfg_i    in   valid/ready   link_type (always ready)
//   rec_o    out  valid/ready   header or payload byte record
//
// One item per cycle sustained while rec_o is not stalled; a record reaches
// rec_o from its byte through the input register, decode and result register.
// Reset clears the parse state and sets link_type to Ethernet.
// A stall on rec_o holds the result register; an empty input register still
// takes one more item before byte_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ipv4_header_parser
  import ethip_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ethip_byte_if.sink  byte_i,
  ethip_cfg_if.sink   cfg_i,
  ethip_rec_if.source rec_o
);

  logic        link_type_q;
  ethip_byte_t in_item;
  ethip_byte_t item;
  logic        item_valid;
  logic        take;
  logic        out_free;
  logic        res_valid;
  ethip_rec_t  res;
  ethip_rec_t  rec;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= 1'b0;
    end else if (cfg_i.valid) begin
      link_type_q <= cfg_i.link_type;
    end
  end

  assign in_item.frame_byte = byte_i.frame_byte;
  assign in_item.frame_end  = byte_i.frame_end;
  assign take               = item_valid && out_free;

  ethip_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (byte_i.ready),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ethip_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_type_i (link_type_q),
    .item_i      (item),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ethip_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .rec_i       (res),
    .free_o      (out_free),
    .out_valid_o (rec_o.valid),
    .out_ready_i (rec_o.ready),
    .rec_o       (rec)
  );

  assign rec_o.record_kind     = rec.record_kind;
  assign rec_o.ip_protocol     = rec.ip_protocol;
  assign rec_o.source_address  = rec.source_address;
  assign rec_o.dest_address    = rec.dest_address;
  assign rec_o.source_port     = rec.source_port;
  assign rec_o.dest_port       = rec.dest_port;
  assign rec_o.sequence_number = rec.sequence_number;
  assign rec_o.ack_number      = rec.ack_number;
  assign rec_o.extra_info      = rec.extra_info;
  assign rec_o.status          = rec.status;
  assign rec_o.payload_byte    = rec.payload_byte;
  assign rec_o.last_of_frame   = rec.last_of_frame;

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !byte_i.ready |-> (rec_o.valid && !rec_o.ready))
    else $error("input stalled without an output stall");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && rec_o.record_kind == KIND_PAYLOAD) |->
      (rec_o.status == STAT_OK && rec_o.ip_protocol == 8'h0 &&
       rec_o.source_address == 32'h0 && rec_o.extra_info == 16'h0))
    else $error("payload record carries header fields");

  a_trunc_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && rec_o.status == STAT_TRUNC) |-> rec_o.last_of_frame)
    else $error("truncated record not last of frame");

  a_short_is_tcp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && rec_o.status == STAT_TCP_SHORT) |->
      (rec_o.ip_protocol == PROTO_TCP && rec_o.record_kind == KIND_HEADER))
    else $error("short header status on non-TCP record");

endmodule

`default_nettype wire

/* rtl/ethip_in_stage.sv */
// ----------------------------------------------------------------------------
// ethip_in_stage
// Input register holding one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ethip_in_stage
  import ethip_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire ethip_byte_t in_item_i,
  output logic             in_ready_o,
  input  wire logic        take_i,
  output logic             item_valid_o,
  output ethip_byte_t      item_o
);

  logic        valid_q;
  ethip_byte_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/ethip_parse_core.sv */
// ----------------------------------------------------------------------------
// ethip_parse_core
// Per-frame parse state and the single-pass decode of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ethip_parse_core
  import ethip_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        link_type_i,
  input  wire ethip_byte_t item_i,
  input  wire logic        take_i,
  output logic             res_valid_o,
  output ethip_rec_t       res_o
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_ETH     = 3'd1;
  localparam logic [2:0] PH_VLAN    = 3'd2;
  localparam logic [2:0] PH_IP      = 3'd3;
  localparam logic [2:0] PH_OPTS    = 3'd4;
  localparam logic [2:0] PH_L4      = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_DROP    = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] etype_q, etype_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] saddr_q, saddr_d;
  logic [31:0] daddr_q, daddr_d;
  logic [31:0] ports_q, ports_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] ack_q, ack_d;
  logic [15:0] info_q, info_d;
  logic        short_q, short_d;

  logic        emit;
  logic        emit_kind;
  logic [1:0]  emit_stat;
  logic        emit_last;

  always_comb begin
    logic [2:0]  ph;
    logic [7:0]  b;
    logic        e;
    logic [5:0]  k;
    logic        ip_done;
    logic [4:0]  l4;
    logic [31:0] b32;
    logic [4:0]  sh4;
    logic [3:0]  sh2;

    b   = item_i.frame_byte;
    e   = item_i.frame_end;
    k   = pos_q;
    b32 = {24'h0, b};
    sh4 = {~k[1:0], 3'b000};
    sh2 = {~k[0], 3'b000};
    ph  = phase_q;
    if (ph == PH_START) begin
      ph = link_type_i ? PH_IP : PH_ETH;
    end

    phase_d   = ph;
    pos_d     = pos_q;
    etype_d   = etype_q;
    ihl_d     = ihl_q;
    rem_d     = rem_q;
    proto_d   = proto_q;
    saddr_d   = saddr_q;
    daddr_d   = daddr_q;
    ports_d   = ports_q;
    seq_d     = seq_q;
    ack_d     = ack_q;
    info_d    = info_q;
    short_d   = short_q;
    emit      = 1'b0;
    emit_kind = KIND_HEADER;
    emit_stat = STAT_OK;
    emit_last = 1'b0;
    ip_done   = 1'b0;
    l4        = l4_len(proto_q);

    case (ph)
      PH_ETH: begin
        if (k >= 6'd12) begin
          etype_d = etype_q | (16'(b) << sh2);
        end
        pos_d = k + 6'd1;
        if (k == 6'd13) begin
          pos_d = 6'd0;
          if (etype_d == ETYPE_VLAN) begin
            etype_d = 16'h0;
            phase_d = PH_VLAN;
          end else begin
            phase_d = (etype_d == ETYPE_IPV4) ? PH_IP : PH_DROP;
          end
        end
      end
      PH_VLAN: begin
        if (k >= 6'd2) begin
          etype_d = etype_q | (16'(b) << sh2);
        end
        pos_d = k + 6'd1;
        if (k == 6'd3) begin
          pos_d   = 6'd0;
          phase_d = (etype_d == ETYPE_IPV4) ? PH_IP : PH_DROP;
        end
      end
      PH_IP: begin
        if (k == 6'd0) begin
          ihl_d = {b[3:0], 2'b00};
        end else if (k == 6'd2) begin
          rem_d = rem_q | {b, 8'h00};
        end else if (k == 6'd3) begin
          rem_d = rem_q | {8'h00, b};
        end else if (k == 6'd9) begin
          proto_d = b;
        end else if (k >= 6'd12 && k < 6'd16) begin
          saddr_d = saddr_q | (b32 << sh4);
        end else if (k >= 6'd16) begin
          daddr_d = daddr_q | (b32 << sh4);
        end
        pos_d = k + 6'd1;
        if (k == 6'd19) begin
          rem_d = (rem_d > {10'h0, ihl_d}) ? rem_d - {10'h0, ihl_d} : 16'h0;
          if (ihl_d > 6'd20) begin
            if (e) begin
              emit      = 1'b1;
              emit_stat = STAT_TRUNC;
              emit_last = 1'b1;
              phase_d   = PH_DROP;
            end else begin
              phase_d = PH_OPTS;
              pos_d   = 6'd0;
            end
          end else begin
            ip_done = 1'b1;
          end
        end else if (e) begin
          emit      = 1'b1;
          emit_stat = STAT_TRUNC;
          emit_last = 1'b1;
          phase_d   = PH_DROP;
        end
      end
      PH_OPTS: begin
        pos_d = k + 6'd1;
        if ({1'b0, k} + 7'd1 >= {1'b0, ihl_q} - 7'd20) begin
          ip_done = 1'b1;
        end else if (e) begin
          emit      = 1'b1;
          emit_stat = STAT_TRUNC;
          emit_last = 1'b1;
          phase_d   = PH_DROP;
        end
      end
      PH_L4: begin
        if (proto_q == PROTO_TCP) begin
          if (k < 6'd4) begin
            ports_d = ports_q | (b32 << sh4);
          end else if (k < 6'd8) begin
            seq_d = seq_q | (b32 << sh4);
          end else if (k < 6'd12) begin
            ack_d = ack_q | (b32 << sh4);
          end else if (k == 6'd12) begin
            short_d = b[7:4] < 4'd5;
          end else if (k == 6'd13) begin
            info_d = {8'h00, b};
          end
        end else if (proto_q == PROTO_UDP) begin
          if (k < 6'd4) begin
            ports_d = ports_q | (b32 << sh4);
          end
        end else if (proto_q == PROTO_ICMP) begin
          if (k < 6'd2) begin
            info_d = info_q | (16'(b) << sh2);
          end
        end
        rem_d = rem_q - 16'd1;
        pos_d = k + 6'd1;
        if ({1'b0, k} + 7'd1 >= {2'b00, l4}) begin
          emit      = 1'b1;
          emit_last = e || (rem_d == 16'h0);
          emit_stat = (proto_q == PROTO_TCP && short_d) ? STAT_TCP_SHORT : STAT_OK;
          phase_d   = emit_last ? PH_DROP : PH_PAYLOAD;
        end else if (e || rem_d == 16'h0) begin
          emit      = 1'b1;
          emit_stat = STAT_TRUNC;
          emit_last = 1'b1;
          phase_d   = PH_DROP;
        end
      end
      PH_PAYLOAD: begin
        rem_d     = rem_q - 16'd1;
        emit      = 1'b1;
        emit_kind = KIND_PAYLOAD;
        emit_last = e || (rem_d == 16'h0);
        if (emit_last) begin
          phase_d = PH_DROP;
        end
      end
      default: begin
      end
    endcase

    if (ip_done) begin
      if (l4_len(proto_d) == 5'd0) begin
        emit      = 1'b1;
        emit_last = e || (rem_d == 16'h0);
        phase_d   = emit_last ? PH_DROP : PH_PAYLOAD;
      end else if (e || rem_d == 16'h0) begin
        emit      = 1'b1;
        emit_stat = STAT_TRUNC;
        emit_last = 1'b1;
        phase_d   = PH_DROP;
      end else begin
        phase_d = PH_L4;
        pos_d   = 6'd0;
      end
    end

    res_o = '0;
    res_o.record_kind   = emit_kind;
    res_o.last_of_frame = emit_last;
    if (emit_kind == KIND_PAYLOAD) begin
      res_o.payload_byte = b;
    end else begin
      res_o.ip_protocol     = proto_d;
      res_o.source_address  = saddr_d;
      res_o.dest_address    = daddr_d;
      res_o.source_port     = ports_d[31:16];
      res_o.dest_port       = ports_d[15:0];
      res_o.sequence_number = seq_d;
      res_o.ack_number      = ack_d;
      res_o.extra_info      = info_d;
      res_o.status          = emit_stat;
    end
  end

  assign res_valid_o = take_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      pos_q   <= '0;
      etype_q <= '0;
      ihl_q   <= '0;
      rem_q   <= '0;
      proto_q <= '0;
      saddr_q <= '0;
      daddr_q <= '0;
      ports_q <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
      info_q  <= '0;
      short_q <= 1'b0;
    end else if (take_i) begin
      if (item_i.frame_end) begin
        phase_q <= PH_START;
        pos_q   <= '0;
        etype_q <= '0;
        ihl_q   <= '0;
        rem_q   <= '0;
        proto_q <= '0;
        saddr_q <= '0;
        daddr_q <= '0;
        ports_q <= '0;
        seq_q   <= '0;
        ack_q   <= '0;
        info_q  <= '0;
        short_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        etype_q <= etype_d;
        ihl_q   <= ihl_d;
        rem_q   <= rem_d;
        proto_q <= proto_d;
        saddr_q <= saddr_d;
        daddr_q <= daddr_d;
        ports_q <= ports_d;
        seq_q   <= seq_d;
        ack_q   <= ack_d;
        info_q  <= info_d;
        short_q <= short_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ethip_out_stage.sv */
// ----------------------------------------------------------------------------
// ethip_out_stage
// Result register holding one record until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ethip_out_stage
  import ethip_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire ethip_rec_t rec_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output ethip_rec_t      rec_o
);

  logic       valid_q;
  ethip_rec_t rec_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

`default_nettype wire
